>>> rtl/pva_pkg.sv
// pva_pkg: shared types, codes and the note frequency table of the voice allocator
// no dependencies; used by the controller, datapath and top level

package pva_pkg;

    localparam int VOICES_DEF = 3;
    localparam int MAX_OUT    = 3;
    localparam int CFG_W      = 4;
    localparam logic [CFG_W-1:0] PERC_RESET = 4'd9;

    localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
    localparam logic [1:0] MODE_TICK     = 2'd2;

    localparam logic KIND_FREQ = 1'b0;
    localparam logic KIND_ATT  = 1'b1;

    localparam logic [4:0] ATT_SILENT = 5'd15;
    localparam logic [4:0] ATT_DONE   = 5'd16;
    localparam logic [6:0] VEL_MAX    = 7'd127;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ON,
        OP_OFF,
        OP_TICK
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FREQ,
        ST_ATT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic ready;
        logic scan_step;
        logic commit;
        logic emit_freq;
        logic emit_att;
        logic flush;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic accepted;
        logic scan_last;
        logic step_hold;
        logic drop;
        logic out_free;
        logic pend_valid;
    } t_sts;

    localparam logic [13:0] NOTE_HZ [128] = '{
        14'd8,     14'd8,     14'd9,     14'd9,     14'd10,    14'd10,    14'd11,    14'd12,
        14'd12,    14'd13,    14'd14,    14'd15,    14'd16,    14'd17,    14'd18,    14'd19,
        14'd20,    14'd21,    14'd23,    14'd24,    14'd25,    14'd27,    14'd29,    14'd30,
        14'd32,    14'd34,    14'd36,    14'd38,    14'd41,    14'd43,    14'd46,    14'd48,
        14'd51,    14'd55,    14'd58,    14'd61,    14'd65,    14'd69,    14'd73,    14'd77,
        14'd82,    14'd87,    14'd92,    14'd97,    14'd103,   14'd110,   14'd116,   14'd123,
        14'd130,   14'd138,   14'd146,   14'd155,   14'd164,   14'd174,   14'd184,   14'd195,
        14'd207,   14'd220,   14'd233,   14'd246,   14'd261,   14'd277,   14'd293,   14'd311,
        14'd329,   14'd349,   14'd369,   14'd391,   14'd415,   14'd440,   14'd466,   14'd493,
        14'd523,   14'd554,   14'd587,   14'd622,   14'd659,   14'd698,   14'd739,   14'd783,
        14'd830,   14'd880,   14'd932,   14'd987,   14'd1046,  14'd1108,  14'd1174,  14'd1244,
        14'd1318,  14'd1396,  14'd1479,  14'd1567,  14'd1661,  14'd1760,  14'd1864,  14'd1975,
        14'd2093,  14'd2217,  14'd2349,  14'd2489,  14'd2637,  14'd2793,  14'd2959,  14'd3135,
        14'd3322,  14'd3520,  14'd3729,  14'd3951,  14'd4186,  14'd4434,  14'd4698,  14'd4978,
        14'd5274,  14'd5587,  14'd5919,  14'd6271,  14'd6644,  14'd7040,  14'd7458,  14'd7902,
        14'd8372,  14'd8869,  14'd9397,  14'd9956,  14'd10548, 14'd11175, 14'd11839, 14'd12543
    };

endpackage

>>> rtl/pva_if.sv
// pva_in_if / pva_out_if: valid-ready channels for note events and tone register writes
// fixed payload widths; no dependencies

interface pva_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;

    modport source (output valid, mode, channel, note, velocity, input ready);
    modport sink   (input valid, mode, channel, note, velocity, output ready);
endinterface

interface pva_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  voice;
    logic        write_kind;
    logic [13:0] frequency;
    logic [3:0]  attenuation;
    logic        last;

    modport source (output valid, voice, write_kind, frequency, attenuation, last,
                    input ready);
    modport sink   (input valid, voice, write_kind, frequency, attenuation, last,
                    output ready);
endinterface

>>> rtl/polyphonic_voice_allocator_unit.sv
// polyphonic_voice_allocator_unit: top level, controller plus datapath
// depends on pva_pkg, pva_if, pva_ctrl and pva_dp
//
// Takes note-on, note-off and decay-tick events on i_evt and answers with tone
// generator register write beats on o_wr, the final beat of an event flagged by last.
// Voices are examined one per clock, except that a tick scan holds while a beat is due
// and the output register is still full. A placed note-on passes scan, decide, a frequency
// beat and an attenuation beat; a dropped note-on ends after decide, a note-off after
// the scan, a tick after the scan and a flush of its pending beat, an ignored event at
// once. Beats wait while the output register is full; results wait in a single output
// register, so the next event is accepted while the last beat is pending. The user must
// write the percussion channel through i_cfg_we / i_cfg_data only while idle; the block does not enforce it.

module polyphonic_voice_allocator_unit #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pva_pkg::CFG_W-1:0] i_cfg_data,
    pva_in_if.sink                    i_evt,
    pva_out_if.source                 o_wr
);

    pva_pkg::t_cmd cmd;
    pva_pkg::t_sts sts;

    pva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pva_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_evt      (i_evt),
        .o_wr       (o_wr),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

>>> rtl/pva_ctrl.sv
// pva_ctrl: sequencer of the voice allocator (accept, voice scan, decide, write beats)
// depends on pva_pkg for the state, command and status types

module pva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pva_pkg::t_sts i_sts,
    output pva_pkg::t_cmd o_cmd
);

    pva_pkg::t_state r_state;
    pva_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pva_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            pva_pkg::ST_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_sts.accepted) begin
                    n_state = pva_pkg::ST_SCAN;
                end
            end
            pva_pkg::ST_SCAN: begin
                if (i_sts.op == pva_pkg::OP_NONE) begin
                    n_state = pva_pkg::ST_IDLE;
                end else if (!i_sts.step_hold) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.scan_last) begin
                        case (i_sts.op)
                            pva_pkg::OP_ON:   n_state = pva_pkg::ST_DECIDE;
                            pva_pkg::OP_TICK: n_state = pva_pkg::ST_FLUSH;
                            default:          n_state = pva_pkg::ST_IDLE;
                        endcase
                    end
                end
            end
            pva_pkg::ST_DECIDE: begin
                if (i_sts.drop) begin
                    n_state = pva_pkg::ST_IDLE;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = pva_pkg::ST_FREQ;
                end
            end
            pva_pkg::ST_FREQ: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_freq = 1'b1;
                    n_state         = pva_pkg::ST_ATT;
                end
            end
            pva_pkg::ST_ATT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_att = 1'b1;
                    n_state        = pva_pkg::ST_IDLE;
                end
            end
            pva_pkg::ST_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = pva_pkg::ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = pva_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pva_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/pva_dp.sv
// pva_dp: voice state, scan accumulators, pending tick beat and output register
// depends on pva_pkg and the pva_in_if / pva_out_if channels

module pva_dp #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pva_pkg::CFG_W-1:0] i_cfg_data,
    pva_in_if.sink                   i_evt,
    pva_out_if.source                o_wr,
    input  pva_pkg::t_cmd            i_cmd,
    output pva_pkg::t_sts            o_sts
);

    localparam int IW = $clog2(VOICES);
    localparam logic [IW-1:0] IDX_LAST = IW'(VOICES - 1);
    localparam logic [1:0]    CNT_MAX  = 2'(pva_pkg::MAX_OUT);

    logic [pva_pkg::CFG_W-1:0] r_perc;
    logic [1:0] r_mode;
    logic [3:0] r_channel;
    logic [6:0] r_note;
    logic [6:0] r_velocity;

    logic [6:0] r_vnote [VOICES];
    logic [4:0] r_vatt  [VOICES];
    logic       r_vdec  [VOICES];

    logic [IW-1:0] r_idx;
    logic          r_same_f, r_idle_f, r_empty_f;
    logic [IW-1:0] r_same_i, r_idle_i, r_empty_i, r_lo_i, r_hi_i;
    logic [6:0]    r_lo_v, r_hi_v;
    logic [1:0]    r_cnt;
    logic [IW-1:0] r_place;
    logic [3:0]    r_att_on;

    logic       r_pend_valid;
    logic [1:0] r_pend_voice;
    logic [3:0] r_pend_att;

    logic        r_out_valid;
    logic [1:0]  r_out_voice;
    logic        r_out_kind;
    logic [13:0] r_out_freq;
    logic [3:0]  r_out_att;
    logic        r_out_last;

    pva_pkg::t_op  op;
    logic          accepted;
    logic          out_free;
    logic          out_load;
    logic [6:0]    cur_note;
    logic [4:0]    cur_att;
    logic          cur_dec;
    logic          produce;
    logic [IW-1:0] mid;
    logic [IW-1:0] n_place;
    logic [3:0]    n_att_on;
    logic [3:0]    n_tick_att;

    assign accepted   = i_evt.valid && i_evt.ready;
    assign out_free   = !r_out_valid || o_wr.ready;
    assign cur_note   = r_vnote[r_idx];
    assign cur_att    = r_vatt[r_idx];
    assign cur_dec    = r_vdec[r_idx];
    assign n_att_on   = 4'((pva_pkg::VEL_MAX - r_velocity) >> 3);
    assign n_tick_att = cur_att[3:0] + 4'd1;
    assign produce    = (op == pva_pkg::OP_TICK) && cur_dec &&
                        (cur_att < pva_pkg::ATT_SILENT) && (r_cnt < CNT_MAX);
    assign out_load   = i_cmd.emit_freq || i_cmd.emit_att ||
                        (i_cmd.scan_step && produce && r_pend_valid) ||
                        (i_cmd.flush && r_pend_valid);

    always_comb begin
        case (r_mode)
            pva_pkg::MODE_NOTE_ON: begin
                if (r_velocity == 7'd0) begin
                    op = pva_pkg::OP_OFF;
                end else if (r_channel == r_perc) begin
                    op = pva_pkg::OP_NONE;
                end else begin
                    op = pva_pkg::OP_ON;
                end
            end
            pva_pkg::MODE_NOTE_OFF: op = pva_pkg::OP_OFF;
            pva_pkg::MODE_TICK:     op = pva_pkg::OP_TICK;
            default:                op = pva_pkg::OP_NONE;
        endcase
    end

    // chosen voice is the same note, else idle, else empty, else the first that is neither lowest nor highest
    always_comb begin
        if (r_lo_i != IW'(0) && r_hi_i != IW'(0)) begin
            mid = IW'(0);
        end else if (r_lo_i != IW'(1) && r_hi_i != IW'(1)) begin
            mid = IW'(1);
        end else begin
            mid = IW'(2);
        end
        if (r_same_f) begin
            n_place = r_same_i;
        end else if (r_idle_f) begin
            n_place = r_idle_i;
        end else if (r_empty_f) begin
            n_place = r_empty_i;
        end else begin
            n_place = mid;
        end
    end

    assign o_sts.op         = op;
    assign o_sts.accepted   = accepted;
    assign o_sts.scan_last  = (r_idx == IDX_LAST);
    assign o_sts.step_hold  = produce && r_pend_valid && !out_free;
    assign o_sts.drop       = !r_same_f && !r_empty_f && (r_note > r_lo_v) && (r_note < r_hi_v);
    assign o_sts.out_free   = out_free;
    assign o_sts.pend_valid = r_pend_valid;

    assign i_evt.ready       = i_cmd.ready;
    assign o_wr.valid        = r_out_valid;
    assign o_wr.voice        = r_out_voice;
    assign o_wr.write_kind   = r_out_kind;
    assign o_wr.frequency    = r_out_freq;
    assign o_wr.attenuation  = r_out_att;
    assign o_wr.last         = r_out_last;

    // configuration and input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perc <= pva_pkg::PERC_RESET;
        end else if (i_cfg_we) begin
            r_perc <= i_cfg_data;
        end
        if (accepted) begin
            r_mode     <= i_evt.mode;
            r_channel  <= i_evt.channel;
            r_note     <= i_evt.note;
            r_velocity <= i_evt.velocity;
        end
    end

    // per-voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_vnote[v] <= 7'd0;
                r_vatt[v]  <= pva_pkg::ATT_SILENT;
                r_vdec[v]  <= 1'b0;
            end
        end else if (i_cmd.commit) begin
            r_vnote[n_place] <= r_note;
            r_vatt[n_place]  <= {1'b0, n_att_on};
            r_vdec[n_place]  <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (op == pva_pkg::OP_OFF && cur_note == r_note) begin
                r_vnote[r_idx] <= 7'd0;
                r_vdec[r_idx]  <= 1'b1;
            end
            if (op == pva_pkg::OP_TICK && cur_dec) begin
                if (cur_att >= pva_pkg::ATT_SILENT) begin
                    r_vatt[r_idx] <= pva_pkg::ATT_DONE;
                    r_vdec[r_idx] <= 1'b0;
                end else begin
                    r_vatt[r_idx] <= cur_att + 5'd1;
                end
            end
        end
    end

    // scan index and search accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (accepted) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= (r_idx == IDX_LAST) ? IW'(0) : r_idx + IW'(1);
        end
        if (accepted) begin
            r_same_f  <= 1'b0;
            r_idle_f  <= 1'b0;
            r_empty_f <= 1'b0;
            r_cnt     <= 2'd0;
        end else if (i_cmd.scan_step) begin
            if (op == pva_pkg::OP_ON) begin
                if (!r_same_f && cur_note == r_note) begin
                    r_same_f <= 1'b1;
                    r_same_i <= r_idx;
                end
                if (!r_idle_f && cur_note == 7'd0 && !cur_dec) begin
                    r_idle_f <= 1'b1;
                    r_idle_i <= r_idx;
                end
                if (!r_empty_f && cur_note == 7'd0) begin
                    r_empty_f <= 1'b1;
                    r_empty_i <= r_idx;
                end
                if (r_idx == IW'(0) || cur_note < r_lo_v) begin
                    r_lo_i <= r_idx;
                    r_lo_v <= cur_note;
                end
                if (r_idx == IW'(0) || cur_note > r_hi_v) begin
                    r_hi_i <= r_idx;
                    r_hi_v <= cur_note;
                end
            end
            if (produce) begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
        if (i_cmd.commit) begin
            r_place  <= n_place;
            r_att_on <= n_att_on;
        end
    end

    // pending tick beat and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (o_wr.valid && o_wr.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            if (accepted) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.emit_freq) begin
                r_out_valid <= 1'b1;
                r_out_voice <= r_place[1:0];
                r_out_kind  <= pva_pkg::KIND_FREQ;
                r_out_freq  <= pva_pkg::NOTE_HZ[r_note];
                r_out_att   <= 4'd0;
                r_out_last  <= 1'b0;
            end
            if (i_cmd.emit_att) begin
                r_out_valid <= 1'b1;
                r_out_voice <= r_place[1:0];
                r_out_kind  <= pva_pkg::KIND_ATT;
                r_out_freq  <= 14'd0;
                r_out_att   <= r_att_on;
                r_out_last  <= 1'b1;
            end
            if (i_cmd.scan_step && produce) begin
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                    r_out_voice <= r_pend_voice;
                    r_out_kind  <= pva_pkg::KIND_ATT;
                    r_out_freq  <= 14'd0;
                    r_out_att   <= r_pend_att;
                    r_out_last  <= 1'b0;
                end
                r_pend_valid <= 1'b1;
                r_pend_voice <= r_idx[1:0];
                r_pend_att   <= n_tick_att;
            end
            if (i_cmd.flush && r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_out_voice  <= r_pend_voice;
                r_out_kind   <= pva_pkg::KIND_ATT;
                r_out_freq   <= 14'd0;
                r_out_att    <= r_pend_att;
                r_out_last   <= 1'b1;
                r_pend_valid <= 1'b0;
            end
        end
    end

endmodule
